// File: rtl/pvc_pkg.sv
package pvc_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int CFG_WIDTH   = 16;
   localparam int CFG_COUNT   = 8;
   localparam int CSR_IDX_W   = 4;
   localparam int CODE_WIDTH  = 16;
   localparam int REM_WIDTH   = CFG_WIDTH + 1;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_IDX_W-1:0] CFG_LOCKOUT    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_RFLOW      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_SFLOW      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_HOLDOFF    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_BLINK_CYC  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_BLINK_TGL  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_PAUSE_CODE = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CFG_FLUSH_CODE = 4'd7;

   localparam logic [CFG_WIDTH-1:0] RST_LOCKOUT    = 16'd300;
   localparam logic [CFG_WIDTH-1:0] RST_RFLOW      = 16'd500;
   localparam logic [CFG_WIDTH-1:0] RST_SFLOW      = 16'd300;
   localparam logic [CFG_WIDTH-1:0] RST_HOLDOFF    = 16'd500;
   localparam logic [CFG_WIDTH-1:0] RST_BLINK_CYC  = 16'd50;
   localparam logic [CFG_WIDTH-1:0] RST_BLINK_TGL  = 16'd25;
   localparam logic [CFG_WIDTH-1:0] RST_PAUSE_CODE = 16'd16575;
   localparam logic [CFG_WIDTH-1:0] RST_FLUSH_CODE = 16'd5865;

   localparam logic [1:0] BLINKS_ENTER = 2'd3;
   localparam logic [1:0] BLINKS_LEAVE = 2'd2;
   localparam logic [1:0] BLINKS_FLUSH = 2'd1;

   typedef struct packed {
      logic capture;
      logic step;
      logic commit;
   } pvc_cmd_type;

   typedef struct packed {
      logic slot_free;
   } pvc_sts_type;

endpackage

// File: rtl/pvc_ctrl.sv
module pvc_ctrl #(
   parameter int COUNT_WIDTH = pvc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pvc_pkg::pvc_sts_type sts,
   output pvc_pkg::pvc_cmd_type cmd
);

   localparam int STEP_W = $clog2(COUNT_WIDTH);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COUNT_WIDTH - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd.capture = 1'b0;
      cmd.step    = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_capture_starts_div: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_DIV) && (step_ff == '0))
      else $error("capture did not start the remainder pass");

   a_div_runs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (step_ff != STEP_LAST) |=> (state_ff == ST_DIV))
      else $error("remainder pass ended early");

endmodule

// File: rtl/pvc_datapath.sv
module pvc_datapath #(
   parameter int COUNT_WIDTH = pvc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_code_valid,
   input  logic [pvc_pkg::CODE_WIDTH-1:0]        req_remote_code,
   input  logic                                  req_presence,
   input  logic                                  csr_we,
   input  logic [pvc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pvc_pkg::CFG_WIDTH-1:0]         csr_data,
   input  pvc_pkg::pvc_cmd_type                  cmd,
   output pvc_pkg::pvc_sts_type                  sts,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic                                  rsp_valve_open,
   output logic                                  rsp_led_on,
   output logic                                  rsp_paused
);

   localparam int CW = COUNT_WIDTH;
   localparam int FW = pvc_pkg::CFG_WIDTH;
   localparam int RW = pvc_pkg::REM_WIDTH;
   localparam logic [31:0] CNT_MAX = 32'((64'd1 << CW) - 64'd1);

   function automatic logic [CW-1:0] sat_load(input logic [FW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w > CNT_MAX) begin
         sat_load = '1;
      end else begin
         sat_load = w[CW-1:0];
      end
   endfunction

   logic [FW-1:0] cfg_lockout_ff, cfg_rflow_ff, cfg_sflow_ff, cfg_holdoff_ff;
   logic [FW-1:0] cfg_blink_cyc_ff, cfg_blink_tgl_ff, cfg_pause_code_ff, cfg_flush_code_ff;

   logic                             code_valid_ff;
   logic [pvc_pkg::CODE_WIDTH-1:0]   code_ff;
   logic                             presence_ff;

   logic [CW-1:0] quo_ff, quo_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] rem_shift;

   logic [CW-1:0] since_ff, since_in;
   logic          pause_ff, pause_in;
   logic [1:0]    blinks_ff, blinks_in;
   logic [CW-1:0] blink_rem_ff, blink_rem_in;
   logic          led_ff, led_in;
   logic [CW-1:0] flow_ff, flow_in;
   logic [CW-1:0] hold_ff, hold_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_data_ff, rsp_data_in;

   logic [CW-1:0] since_inc;
   logic          cmd_ok, pause_hit, flush_hit;
   logic [1:0]    blinks_a;
   logic [CW-1:0] flow_a, flow_b, hold_a;
   logic          valve;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_lockout_ff    <= pvc_pkg::RST_LOCKOUT;
         cfg_rflow_ff      <= pvc_pkg::RST_RFLOW;
         cfg_sflow_ff      <= pvc_pkg::RST_SFLOW;
         cfg_holdoff_ff    <= pvc_pkg::RST_HOLDOFF;
         cfg_blink_cyc_ff  <= pvc_pkg::RST_BLINK_CYC;
         cfg_blink_tgl_ff  <= pvc_pkg::RST_BLINK_TGL;
         cfg_pause_code_ff <= pvc_pkg::RST_PAUSE_CODE;
         cfg_flush_code_ff <= pvc_pkg::RST_FLUSH_CODE;
      end else if (csr_we) begin
         case (csr_index)
            pvc_pkg::CFG_LOCKOUT:    cfg_lockout_ff    <= csr_data;
            pvc_pkg::CFG_RFLOW:      cfg_rflow_ff      <= csr_data;
            pvc_pkg::CFG_SFLOW:      cfg_sflow_ff      <= csr_data;
            pvc_pkg::CFG_HOLDOFF:    cfg_holdoff_ff    <= csr_data;
            pvc_pkg::CFG_BLINK_CYC:  cfg_blink_cyc_ff  <= csr_data;
            pvc_pkg::CFG_BLINK_TGL:  cfg_blink_tgl_ff  <= csr_data;
            pvc_pkg::CFG_PAUSE_CODE: cfg_pause_code_ff <= csr_data;
            pvc_pkg::CFG_FLUSH_CODE: cfg_flush_code_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_valid_ff <= req_code_valid;
         code_ff       <= req_remote_code;
         presence_ff   <= req_presence;
      end
   end

   assign rem_shift = {rem_ff[RW-2:0], quo_ff[CW-1]};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.capture) begin
         quo_in = blink_rem_ff;
         rem_in = '0;
      end else if (cmd.step) begin
         quo_in = {quo_ff[CW-2:0], 1'b0};
         if (rem_shift >= RW'(cfg_blink_tgl_ff)) begin
            rem_in = rem_shift - RW'(cfg_blink_tgl_ff);
         end else begin
            rem_in = rem_shift;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      since_in     = since_ff;
      pause_in     = pause_ff;
      blinks_in    = blinks_ff;
      blink_rem_in = blink_rem_ff;
      led_in       = led_ff;
      flow_in      = flow_ff;
      hold_in      = hold_ff;

      since_inc = (since_ff != '1) ? CW'(since_ff + 1'b1) : since_ff;
      cmd_ok    = code_valid_ff && (32'(since_inc) > 32'(cfg_lockout_ff));
      pause_hit = cmd_ok && (code_ff == cfg_pause_code_ff);
      flush_hit = cmd_ok && !pause_hit && (code_ff == cfg_flush_code_ff);

      blinks_a = blinks_ff;
      flow_a   = flow_ff;
      if (pause_hit) begin
         blinks_a = pause_ff ? pvc_pkg::BLINKS_LEAVE : pvc_pkg::BLINKS_ENTER;
      end else if (flush_hit) begin
         blinks_a = pvc_pkg::BLINKS_FLUSH;
         flow_a   = sat_load(cfg_rflow_ff);
      end

      valve  = (flow_a != '0);
      flow_b = valve ? CW'(flow_a - 1'b1) : flow_a;
      hold_a = (hold_ff != '0) ? CW'(hold_ff - 1'b1) : hold_ff;

      if (cmd.commit) begin
         since_in  = (pause_hit || flush_hit) ? '0 : since_inc;
         pause_in  = pause_ff ^ pause_hit;
         blinks_in = blinks_a;
         if (blink_rem_ff != '0) begin
            if ((cfg_blink_tgl_ff != '0) && (rem_ff == '0)) begin
               led_in = ~led_ff;
            end
            blink_rem_in = CW'(blink_rem_ff - 1'b1);
         end else begin
            if (blinks_a != 2'd0) begin
               blinks_in    = blinks_a - 2'd1;
               blink_rem_in = sat_load(cfg_blink_cyc_ff);
            end
            led_in = 1'b0;
         end
         if (!pause_in && presence_ff && (hold_a == '0)) begin
            flow_in = sat_load(cfg_sflow_ff);
            hold_in = sat_load(cfg_holdoff_ff);
         end else begin
            flow_in = flow_b;
            hold_in = hold_a;
         end
      end
   end

   assign sts.slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {pause_in, led_in, valve};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         since_ff     <= '0;
         pause_ff     <= 1'b0;
         blinks_ff    <= 2'd0;
         blink_rem_ff <= '0;
         led_ff       <= 1'b0;
         flow_ff      <= '0;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         since_ff     <= since_in;
         pause_ff     <= pause_in;
         blinks_ff    <= blinks_in;
         blink_rem_ff <= blink_rem_in;
         led_ff       <= led_in;
         flow_ff      <= flow_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_valve_open = rsp_data_ff[0];
   assign rsp_led_on     = rsp_data_ff[1];
   assign rsp_paused     = rsp_data_ff[2];

   a_commit_shows_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff && (rsp_data_ff[2] == pause_ff))
      else $error("commit did not load the result register");

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (cfg_blink_tgl_ff != '0) |-> (rem_ff < RW'(cfg_blink_tgl_ff)))
      else $error("remainder not reduced below toggle period");

endmodule

// File: rtl/presence_valve_controller.sv
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tuser: code_valid; tdata: remote_code, presence
// rsp      out        rsp_tvalid/tready    tdata: valve_open, led_on, paused
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// A transaction is captured, then runs COUNT_WIDTH steps of the bit-serial remainder unit
// for the LED toggle test, then commits. A new req transaction is taken once the previous
// one commits, while its result may still wait in the rsp register; commit stalls only
// while that register is full and not taken. Reset is synchronous, active high, and loads
// the register defaults; csr is always ready.
module presence_valve_controller #(
   parameter int COUNT_WIDTH = pvc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,  // [0] code_valid
   input  logic [pvc_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] remote_code, [16] presence
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pvc_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // [0] valve_open, [1] led_on, [2] paused
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pvc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pvc_pkg::CFG_WIDTH-1:0]     csr_data
);

   pvc_pkg::pvc_cmd_type cmd;
   pvc_pkg::pvc_sts_type sts;
   logic                 valve_open, led_on, paused;

   assign csr_ready = 1'b1;

   pvc_ctrl #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pvc_datapath #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_code_valid  (req_tuser),
      .req_remote_code (req_tdata[pvc_pkg::CODE_WIDTH-1:0]),
      .req_presence    (req_tdata[pvc_pkg::CODE_WIDTH]),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_valve_open  (valve_open),
      .rsp_led_on      (led_on),
      .rsp_paused      (paused)
   );

   assign rsp_tdata = {(pvc_pkg::RSP_DATA_W - 3)'(0), paused, led_on, valve_open};

endmodule

// File: verif/presence_valve_checker.sv
module presence_valve_checker
   import pvc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  req_tuser,   // [0] code_valid
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] remote_code, [16] presence
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] valve_open, [1] led_on, [2] paused
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_WIDTH-1:0]  csr_data,
   output int                    mismatch_count,
   output int                    results_left,
   output int                    results_checked
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic valve_open;
      logic led_on;
      logic paused;
   } drive_levels_type;

   logic [CFG_WIDTH-1:0]   settings [CFG_COUNT];
   logic [COUNT_WIDTH-1:0] since_command;
   logic                   pause_mode;
   logic [1:0]             blinks_queued;
   logic [COUNT_WIDTH-1:0] blink_left;
   logic                   led_level;
   logic [COUNT_WIDTH-1:0] flow_left;
   logic [COUNT_WIDTH-1:0] holdoff_left;
   drive_levels_type       due_levels [$];
   int                     fail_total = 0;
   int                     compared = 0;

   function automatic logic [COUNT_WIDTH-1:0] clamp_load(input logic [CFG_WIDTH-1:0] value);
      if (COUNT_WIDTH < CFG_WIDTH && (32'(value) >> COUNT_WIDTH) != 0)
         return COUNT_MAX;
      return COUNT_WIDTH'(value);
   endfunction

   task automatic note_failure(input string detail);
      fail_total++;
      if (fail_total <= 10)
         $display("%0t  mismatch: %s", $time, detail);
   endtask

   task automatic run_tick(input logic code_valid, input logic [CODE_WIDTH-1:0] code,
                           input logic presence, output drive_levels_type levels);
      if (since_command != COUNT_MAX)
         since_command = since_command + 1'b1;
      if (code_valid && since_command > settings[CFG_LOCKOUT]) begin
         // pause wins when both codes are equal
         if (code == settings[CFG_PAUSE_CODE]) begin
            since_command = '0;
            pause_mode    = ~pause_mode;
            blinks_queued = pause_mode ? BLINKS_ENTER : BLINKS_LEAVE;
         end else if (code == settings[CFG_FLUSH_CODE]) begin
            since_command = '0;
            flow_left     = clamp_load(settings[CFG_RFLOW]);
            blinks_queued = BLINKS_FLUSH;
         end
      end

      if (blink_left != '0) begin
         if (settings[CFG_BLINK_TGL] != '0 && (blink_left % settings[CFG_BLINK_TGL]) == '0)
            led_level = ~led_level;
         blink_left = blink_left - 1'b1;
      end else begin
         if (blinks_queued != '0) begin
            blinks_queued = blinks_queued - 1'b1;
            blink_left    = clamp_load(settings[CFG_BLINK_CYC]);
         end
         led_level = 1'b0;
      end

      levels.valve_open = (flow_left != '0);
      if (flow_left != '0)
         flow_left = flow_left - 1'b1;
      if (holdoff_left != '0)
         holdoff_left = holdoff_left - 1'b1;

      // a trigger shows on the valve from the next tick
      if (!pause_mode && presence && holdoff_left == '0) begin
         flow_left    = clamp_load(settings[CFG_SFLOW]);
         holdoff_left = clamp_load(settings[CFG_HOLDOFF]);
      end
      levels.led_on = led_level;
      levels.paused = pause_mode;
   endtask

   always @(posedge clock) begin : watch
      drive_levels_type seen;
      drive_levels_type want;
      if (reset) begin
         settings[CFG_LOCKOUT]    = RST_LOCKOUT;
         settings[CFG_RFLOW]      = RST_RFLOW;
         settings[CFG_SFLOW]      = RST_SFLOW;
         settings[CFG_HOLDOFF]    = RST_HOLDOFF;
         settings[CFG_BLINK_CYC]  = RST_BLINK_CYC;
         settings[CFG_BLINK_TGL]  = RST_BLINK_TGL;
         settings[CFG_PAUSE_CODE] = RST_PAUSE_CODE;
         settings[CFG_FLUSH_CODE] = RST_FLUSH_CODE;
         since_command = '0;
         pause_mode    = 1'b0;
         blinks_queued = '0;
         blink_left    = '0;
         led_level     = 1'b0;
         flow_left     = '0;
         holdoff_left  = '0;
         due_levels.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < CFG_COUNT)
            settings[csr_index[$clog2(CFG_COUNT)-1:0]] = csr_data;

         if (rsp_tvalid && rsp_tready) begin
            seen.valve_open = rsp_tdata[0];
            seen.led_on     = rsp_tdata[1];
            seen.paused     = rsp_tdata[2];
            compared++;
            if (due_levels.size() == 0) begin
               note_failure($sformatf("valve/led/paused %b/%b/%b with nothing outstanding",
                                      seen.valve_open, seen.led_on, seen.paused));
            end else begin
               want = due_levels.pop_front();
               if (seen !== want)
                  note_failure($sformatf(
                     "transaction %0d valve/led/paused expected %b/%b/%b, got %b/%b/%b",
                     compared, want.valve_open, want.led_on, want.paused,
                     seen.valve_open, seen.led_on, seen.paused));
            end
         end

         if (req_tvalid && req_tready) begin
            run_tick(req_tuser, req_tdata[CODE_WIDTH-1:0], req_tdata[CODE_WIDTH], want);
            due_levels.push_back(want);
         end
      end
      mismatch_count  <= fail_total;
      results_left    <= due_levels.size();
      results_checked <= compared;
   end

endmodule

// File: verif/tb_presence_valve_controller.sv
module tb_presence_valve_controller;
   import pvc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CFG_UNMAPPED = 4'd13;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;      // [0] code_valid
   logic [REQ_DATA_W-1:0] req_tdata = '0;        // [15:0] remote_code, [16] presence
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;             // [0] valve_open, [1] led_on, [2] paused
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_WIDTH-1:0]  csr_data = '0;

   logic                  rsp_hold = 1'b0;
   int                    send_idle_pct = 0;
   int                    rcv_idle_pct = 0;
   int                    mismatch_count;
   int                    results_left;
   int                    results_checked;
   int                    ticks_sent = 0;
   int                    settings_used = 0;
   int                    drain_wait;
   logic [CFG_WIDTH-1:0]  plan [CFG_COUNT];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= rsp_hold ? 1'b0 : ($urandom_range(99) >= rcv_idle_pct);
   end

   presence_valve_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   presence_valve_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_left    (results_left),
      .results_checked (results_checked)
   );

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_tick(input logic code_valid, input logic [CODE_WIDTH-1:0] code,
                            input logic presence);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code_valid;
      req_tdata  <= {{(REQ_DATA_W-CODE_WIDTH-1){1'b0}}, presence, code};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ticks_sent++;
   endtask

   task automatic random_ticks(input int count);
      logic                  code_valid;
      logic [CODE_WIDTH-1:0] code;
      int                    pick;
      repeat (count) begin
         pick = $urandom_range(9);
         if (pick < 4)
            code = plan[CFG_PAUSE_CODE];
         else if (pick < 8)
            code = plan[CFG_FLUSH_CODE];
         else
            code = CODE_WIDTH'($urandom);
         code_valid = ($urandom_range(99) < 35);
         send_tick(code_valid, code, $urandom_range(99) < 40);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_drained;
      @(posedge clock);
      while (results_left != 0)
         @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_WIDTH-1:0] lockout, rflow, sflow, holdoff,
                            cycle, toggle, pcode, fcode, input bit stray);
      wait_drained();
      plan[CFG_LOCKOUT]    = lockout;
      plan[CFG_RFLOW]      = rflow;
      plan[CFG_SFLOW]      = sflow;
      plan[CFG_HOLDOFF]    = holdoff;
      plan[CFG_BLINK_CYC]  = cycle;
      plan[CFG_BLINK_TGL]  = toggle;
      plan[CFG_PAUSE_CODE] = pcode;
      plan[CFG_FLUSH_CODE] = fcode;
      for (int i = 0; i < CFG_COUNT; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= plan[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      // unmapped index must not land on any register
      if (stray) begin
         csr_index <= CFG_UNMAPPED;
         csr_data  <= '0;
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic configure_random;
      configure(CFG_WIDTH'($urandom_range(8)), CFG_WIDTH'($urandom_range(30)),
                CFG_WIDTH'($urandom_range(20)), CFG_WIDTH'($urandom_range(40)),
                CFG_WIDTH'($urandom_range(20)), CFG_WIDTH'($urandom_range(6)),
                CFG_WIDTH'($urandom), CFG_WIDTH'($urandom), 1'b0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 7;
      rcv_idle_pct  = 65;

      // default registers: commands still inside the lockout
      send_tick(1'b1, RST_PAUSE_CODE, 1'b0);
      send_tick(1'b1, RST_FLUSH_CODE, 1'b0);
      send_tick(1'b0, 16'hFFFF, 1'b0);
      req_tvalid <= 1'b0;

      configure(16'd3, 16'd6, 16'd4, 16'd9, 16'd6, 16'd2, 16'h0000, 16'hFFFF, 1'b1);
      send_tick(1'b1, plan[CFG_FLUSH_CODE], 1'b0);
      send_tick(1'b1, plan[CFG_PAUSE_CODE], 1'b0);
      send_tick(1'b0, 16'hAAAA, 1'b0);
      send_tick(1'b0, 16'h5555, 1'b0);
      send_tick(1'b0, 16'h0000, 1'b0);
      send_tick(1'b1, plan[CFG_PAUSE_CODE], 1'b0);
      send_tick(1'b0, 16'h1234, 1'b1);
      send_tick(1'b1, 16'h8001, 1'b1);
      send_tick(1'b1, 16'h7FFE, 1'b0);
      send_tick(1'b0, 16'h0000, 1'b0);
      send_tick(1'b0, 16'h0000, 1'b0);
      send_tick(1'b1, plan[CFG_PAUSE_CODE], 1'b0);
      send_tick(1'b0, 16'h0000, 1'b1);
      send_tick(1'b0, 16'h0000, 1'b1);
      send_tick(1'b1, plan[CFG_FLUSH_CODE], 1'b1);
      send_tick(1'b1, plan[CFG_FLUSH_CODE], 1'b0);
      send_tick(1'b0, plan[CFG_FLUSH_CODE], 1'b1);
      random_ticks(300);

      // zero lengths, equal codes, no lockout
      configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'h1234, 16'h1234, 1'b0);
      random_ticks(200);

      send_idle_pct = 65;
      rcv_idle_pct  = 7;
      configure(16'd5, 16'd20, 16'd7, 16'd15, 16'd12, 16'd0,
                CFG_WIDTH'($urandom), CFG_WIDTH'($urandom), 1'b0);
      random_ticks(300);
      repeat (2) begin
         configure_random();
         random_ticks(75);
      end

      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      configure(16'd1, 16'd40, 16'd25, 16'd60, 16'd30, 16'd7,
                CFG_WIDTH'($urandom), CFG_WIDTH'($urandom), 1'b0);
      fork
         random_ticks(300);
         begin
            // hold the result side while the sender keeps offering
            repeat (30) @(posedge clock);
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join
      repeat (4) begin
         configure_random();
         random_ticks(60);
      end

      // largest values: every command locked out, longest flows
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'h0000, 1'b0);
      random_ticks(150);

      @(posedge clock);
      drain_wait = 0;
      while (results_left != 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (40) @(posedge clock);

      $display("Sent %0d control ticks under %0d register settings, %0d results compared.",
               ticks_sent, settings_used, results_checked);
      $display("Run included lockout edges, both pause directions, flushes, blink playback, %s",
               "presence holdoff and a long result stall.");
      if (mismatch_count == 0 && results_left == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
